@@ rtl/drcvs_pkg.sv @@
// Shared types, codes and CRC-32 step function for the dual-copy replica selector.
package drcvs_pkg;

    localparam int MAX_PAYLOAD_BYTES = 4096;

    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BYTES  = 2'd1;
    localparam logic [1:0] CMD_DECIDE = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NONE     = 2'd1;
    localparam logic [1:0] STATUS_CONFLICT = 2'd2;
    localparam logic [1:0] STATUS_CAPACITY = 2'd3;

    localparam logic [1:0] CFG_MAGIC       = 2'd0;
    localparam logic [1:0] CFG_VERSION     = 2'd1;
    localparam logic [1:0] CFG_HDR_BYTES   = 2'd2;
    localparam logic [1:0] CFG_FINGERPRINT = 2'd3;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] hdr_bytes;
        logic [31:0] fingerprint;
    } cfg_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] size;
        logic [31:0] fingerprint;
        logic [63:0] seq_num;
        logic [31:0] length;
        logic [31:0] crc;
    } hdr_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic step;
    } copy_ctl_t;

    typedef struct packed {
        logic        valid;
        logic        in_range;
        logic [63:0] seq_num;
        logic [31:0] length;
    } copy_info_t;

    // reflected CRC-32, one byte, bitwise unrolled
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

@@ rtl/drcvs_copy.sv @@
// One copy's header state, running CRC and validity check.
module drcvs_copy (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  drcvs_pkg::cfg_t       cfg,
    input  drcvs_pkg::copy_ctl_t  ctl,
    input  drcvs_pkg::hdr_t       hdr,
    input  logic [7:0]            data_byte,
    input  logic [15:0]           byte_pos,
    output drcvs_pkg::copy_info_t info
);

    logic [63:0] seq_reg;
    logic [31:0] len_reg;
    logic [31:0] stored_crc_reg;
    logic        fields_ok_reg;
    logic [31:0] run_crc_reg;
    logic [31:0] run_crc_next;
    logic        fields_ok;
    logic        in_range;

    assign fields_ok = (hdr.magic == cfg.magic) &&
                       (hdr.version == cfg.version) &&
                       (hdr.size == cfg.hdr_bytes) &&
                       (hdr.fingerprint == cfg.fingerprint) &&
                       (hdr.seq_num != 64'd0) &&
                       (hdr.length != 32'd0) &&
                       (hdr.length <= 32'(drcvs_pkg::MAX_PAYLOAD_BYTES));

    assign in_range = {16'd0, byte_pos} < len_reg;

    always_comb begin
        run_crc_next = run_crc_reg;
        if (ctl.restart) begin
            run_crc_next = drcvs_pkg::CRC_ONES;
        end else if (ctl.step && in_range) begin
            run_crc_next = drcvs_pkg::crc_byte(run_crc_reg, data_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= '0;
            len_reg        <= '0;
            stored_crc_reg <= '0;
            fields_ok_reg  <= 1'b0;
            run_crc_reg    <= drcvs_pkg::CRC_ONES;
        end else begin
            run_crc_reg <= run_crc_next;
            if (ctl.load) begin
                seq_reg        <= hdr.seq_num;
                len_reg        <= hdr.length;
                stored_crc_reg <= hdr.crc;
                fields_ok_reg  <= fields_ok;
            end
        end
    end

    assign info.valid    = fields_ok_reg && ({16'd0, byte_pos} >= len_reg) &&
                           ((run_crc_reg ^ drcvs_pkg::CRC_ONES) == stored_crc_reg);
    assign info.in_range = in_range;
    assign info.seq_num  = seq_reg;
    assign info.length   = len_reg;

endmodule

@@ rtl/dual_copy_replica_validate_select_top.sv @@
// Top level: dual-copy replica CRC validation and copy selection.
//
//   channel  | signals                          | moves
//   ---------+----------------------------------+-------------------------------
//   s_       | s_valid / s_ready, s_* fields    | command word in
//   m_       | m_valid / m_ready, m_* fields    | decision word out (decide only)
//   cfg_     | cfg_wr_en, cfg_index, cfg_wdata  | register write, no wait
//
// A word lands in the input register, then is executed from it once it may advance:
// header load or CRC byte step updates state, decide fills the result register.
// One word per cycle sustained unless a decide waits; m_valid is registered when a decide executes.
// A decide word waits in the input register only while the result register is full
// and not being taken. Synchronous active-low reset; no clearing pass.
module dual_copy_replica_validate_select_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic        s_which_copy,
    input  logic [31:0] s_hdr_magic,
    input  logic [15:0] s_hdr_version,
    input  logic [15:0] s_hdr_size,
    input  logic [31:0] s_hdr_fingerprint,
    input  logic [63:0] s_hdr_sequence,
    input  logic [31:0] s_hdr_length,
    input  logic [31:0] s_hdr_crc,
    input  logic [7:0]  s_primary_byte,
    input  logic [7:0]  s_mirror_byte,
    input  logic [31:0] s_capacity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_selected_copy,
    output logic [31:0] m_out_length,
    output logic        m_primary_valid,
    output logic        m_mirror_valid
);

    drcvs_pkg::cfg_t cfg_reg;

    logic             in_valid_reg;
    logic [1:0]       cmd_reg;
    logic             which_reg;
    drcvs_pkg::hdr_t  hdr_reg;
    logic [7:0]       pbyte_reg;
    logic [7:0]       mbyte_reg;
    logic [31:0]      cap_reg;

    logic [15:0] byte_pos_reg;
    logic        differ_reg;

    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic        sel_reg;
    logic [31:0] out_len_reg;
    logic        pv_reg;
    logic        mv_reg;

    logic                   advance;
    logic                   do_load;
    logic                   do_step;
    logic                   do_decide;
    drcvs_pkg::copy_ctl_t   p_ctl;
    drcvs_pkg::copy_ctl_t   m_ctl;
    drcvs_pkg::copy_info_t  p_info;
    drcvs_pkg::copy_info_t  m_info;

    logic [1:0]  status_next;
    logic        sel_next;
    logic [31:0] len_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                drcvs_pkg::CFG_MAGIC:       cfg_reg.magic       <= cfg_wdata;
                drcvs_pkg::CFG_VERSION:     cfg_reg.version     <= cfg_wdata[15:0];
                drcvs_pkg::CFG_HDR_BYTES:   cfg_reg.hdr_bytes   <= cfg_wdata[15:0];
                drcvs_pkg::CFG_FINGERPRINT: cfg_reg.fingerprint <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    assign advance = in_valid_reg &&
                     ((cmd_reg != drcvs_pkg::CMD_DECIDE) || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg             <= s_command;
            which_reg           <= s_which_copy;
            hdr_reg.magic       <= s_hdr_magic;
            hdr_reg.version     <= s_hdr_version;
            hdr_reg.size        <= s_hdr_size;
            hdr_reg.fingerprint <= s_hdr_fingerprint;
            hdr_reg.seq_num     <= s_hdr_sequence;
            hdr_reg.length      <= s_hdr_length;
            hdr_reg.crc         <= s_hdr_crc;
            pbyte_reg           <= s_primary_byte;
            mbyte_reg           <= s_mirror_byte;
            cap_reg             <= s_capacity;
        end
    end

    // execute stage
    assign do_load   = advance && (cmd_reg == drcvs_pkg::CMD_LOAD);
    assign do_step   = advance && (cmd_reg == drcvs_pkg::CMD_BYTES);
    assign do_decide = advance && (cmd_reg == drcvs_pkg::CMD_DECIDE);

    assign p_ctl.load    = do_load && !which_reg;
    assign p_ctl.restart = do_load;
    assign p_ctl.step    = do_step;
    assign m_ctl.load    = do_load && which_reg;
    assign m_ctl.restart = do_load;
    assign m_ctl.step    = do_step;

    drcvs_copy u_primary (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .ctl       (p_ctl),
        .hdr       (hdr_reg),
        .data_byte (pbyte_reg),
        .byte_pos  (byte_pos_reg),
        .info      (p_info)
    );

    drcvs_copy u_mirror (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .ctl       (m_ctl),
        .hdr       (hdr_reg),
        .data_byte (mbyte_reg),
        .byte_pos  (byte_pos_reg),
        .info      (m_info)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= '0;
            differ_reg   <= 1'b0;
        end else if (do_load) begin
            byte_pos_reg <= '0;
            differ_reg   <= 1'b0;
        end else if (do_step) begin
            if (byte_pos_reg != 16'hFFFF) begin
                byte_pos_reg <= byte_pos_reg + 16'd1;
            end
            if (p_info.in_range && m_info.in_range && (pbyte_reg != mbyte_reg)) begin
                differ_reg <= 1'b1;
            end
        end
    end

    // decision
    always_comb begin
        status_next = drcvs_pkg::STATUS_OK;
        sel_next    = 1'b0;
        len_next    = '0;
        if (!p_info.valid && !m_info.valid) begin
            status_next = drcvs_pkg::STATUS_NONE;
        end else if (p_info.valid && m_info.valid && (p_info.seq_num == m_info.seq_num) &&
                     ((p_info.length != m_info.length) || differ_reg)) begin
            status_next = drcvs_pkg::STATUS_CONFLICT;
        end else begin
            if (p_info.valid && m_info.valid) begin
                sel_next = m_info.seq_num > p_info.seq_num;
            end else begin
                sel_next = !p_info.valid;
            end
            len_next = sel_next ? m_info.length : p_info.length;
            if (cap_reg < len_next) begin
                status_next = drcvs_pkg::STATUS_CAPACITY;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_decide) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_decide) begin
            status_reg  <= status_next;
            sel_reg     <= sel_next;
            out_len_reg <= len_next;
            pv_reg      <= p_info.valid;
            mv_reg      <= m_info.valid;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_selected_copy = sel_reg;
    assign m_out_length    = out_len_reg;
    assign m_primary_valid = pv_reg;
    assign m_mirror_valid  = mv_reg;

endmodule
